>>> rtl/core/i2a_pkg.sv
// shared types, constants and glyph lookup for the integer to ascii formatter
package i2a_pkg;

   localparam int VALUE_W  = 32;
   localparam int DIGIT_W  = 4;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W    = BCD_DIGITS * DIGIT_W;
   localparam int WIDTH_W  = 6;
   localparam int NDIG_W   = 4;
   localparam int CHAR_W   = 8;
   localparam int BIT_CNT_W = 5;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h41;

   localparam logic CONV_DEC = 1'b0;
   localparam logic CONV_HEX = 1'b1;

   // load command from the top level to the character sequencer
   typedef struct packed {
      logic               load;
      logic               neg;
      logic [BCD_W-1:0]   digits;
      logic [WIDTH_W-1:0] width;
   } emit_cmd_type;

   // ascii glyph of one digit, 0-9 then A-F
   function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] g;
      if (d < 4'd10) begin
         g = CHAR_ZERO + {4'b0, d};
      end else begin
         g = CHAR_ALPHA + {4'b0, d} - 8'd10;
      end
      return g;
   endfunction

endpackage

>>> rtl/core/i2a_dabble.sv
// bit-serial binary to bcd converter, one magnitude bit per cycle
module i2a_dabble (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [i2a_pkg::VALUE_W-1:0]     magnitude,
   output logic [i2a_pkg::BCD_W-1:0]       bcd,
   output logic                            done
);

   logic [i2a_pkg::VALUE_W-1:0]   bin_ff, bin_in;
   logic [i2a_pkg::BCD_W-1:0]     bcd_ff, bcd_in;
   logic [i2a_pkg::BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [i2a_pkg::BCD_W-1:0]     adj;

   // add three to every bcd digit of five or more before the shift
   always_comb begin
      for (int k = 0; k < i2a_pkg::BCD_DIGITS; k++) begin
         if (bcd_ff[k*4 +: 4] >= 4'd5) begin
            adj[k*4 +: 4] = bcd_ff[k*4 +: 4] + 4'd3;
         end else begin
            adj[k*4 +: 4] = bcd_ff[k*4 +: 4];
         end
      end
   end

   // shift sequencing
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (load) begin
         bin_in = magnitude;
         bcd_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         bin_in = {bin_ff[i2a_pkg::VALUE_W-2:0], 1'b0};
         bcd_in = {adj[i2a_pkg::BCD_W-2:0], bin_ff[i2a_pkg::VALUE_W-1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd  = bcd_ff;
   assign done = done_ff;

endmodule

>>> rtl/core/i2a_emit.sv
// character sequencer: strips leading zero digits, then sends sign, padding and digits
module i2a_emit #(
   parameter int MAX_DIGITS = 49
) (
   input  logic                          clock,
   input  logic                          reset,
   input  i2a_pkg::emit_cmd_type         cmd,
   output logic                          done,
   output logic                          active,
   output logic                          strobe,
   output logic [i2a_pkg::CHAR_W-1:0]    character,
   output logic                          last
);

   localparam logic [i2a_pkg::WIDTH_W-1:0] MaxWidth = i2a_pkg::WIDTH_W'(MAX_DIGITS);

   typedef enum logic [2:0] {
      E_IDLE = 3'b001,
      E_NORM = 3'b010,
      E_OUT  = 3'b100
   } emit_state_type;

   emit_state_type                 state_ff, state_in;
   logic [i2a_pkg::BCD_W-1:0]      dig_ff, dig_in;
   logic [i2a_pkg::NDIG_W-1:0]     ndig_ff, ndig_in;
   logic [i2a_pkg::WIDTH_W-1:0]    width_ff, width_in;
   logic [i2a_pkg::WIDTH_W-1:0]    pad_ff, pad_in;
   logic                           neg_ff, neg_in;
   logic                           strobe_ff, strobe_in;
   logic                           last_ff, last_in;
   logic [i2a_pkg::CHAR_W-1:0]     char_ff, char_in;
   logic                           done_in;
   logic [i2a_pkg::WIDTH_W-1:0]    wsat;
   logic [i2a_pkg::WIDTH_W-1:0]    ndig_ext;
   logic [i2a_pkg::DIGIT_W-1:0]    top_digit;

   assign wsat      = (width_ff > MaxWidth) ? MaxWidth : width_ff;
   assign ndig_ext  = {{(i2a_pkg::WIDTH_W-i2a_pkg::NDIG_W){1'b0}}, ndig_ff};
   assign top_digit = dig_ff[i2a_pkg::BCD_W-1 -: i2a_pkg::DIGIT_W];

   // sequencer
   always_comb begin
      state_in  = state_ff;
      dig_in    = dig_ff;
      ndig_in   = ndig_ff;
      width_in  = width_ff;
      pad_in    = pad_ff;
      neg_in    = neg_ff;
      strobe_in = 1'b0;
      last_in   = 1'b0;
      char_in   = char_ff;
      done_in   = 1'b0;
      case (state_ff)
         E_IDLE: begin
            if (cmd.load) begin
               dig_in   = cmd.digits;
               ndig_in  = i2a_pkg::NDIG_W'(i2a_pkg::BCD_DIGITS);
               width_in = cmd.width;
               neg_in   = cmd.neg;
               state_in = E_NORM;
            end
         end
         E_NORM: begin
            // drop one leading zero digit a cycle, keep at least one digit
            if (top_digit == '0 && ndig_ff > 4'd1) begin
               dig_in  = {dig_ff[i2a_pkg::BCD_W-i2a_pkg::DIGIT_W-1:0],
                          {i2a_pkg::DIGIT_W{1'b0}}};
               ndig_in = ndig_ff - 1'b1;
            end else begin
               pad_in   = (wsat > ndig_ext) ? wsat - ndig_ext : '0;
               state_in = E_OUT;
            end
         end
         E_OUT: begin
            strobe_in = 1'b1;
            if (neg_ff) begin
               char_in = i2a_pkg::CHAR_MINUS;
               neg_in  = 1'b0;
            end else if (pad_ff != '0) begin
               char_in = i2a_pkg::CHAR_ZERO;
               pad_in  = pad_ff - 1'b1;
            end else begin
               char_in = i2a_pkg::glyph(top_digit);
               dig_in  = {dig_ff[i2a_pkg::BCD_W-i2a_pkg::DIGIT_W-1:0],
                          {i2a_pkg::DIGIT_W{1'b0}}};
               ndig_in = ndig_ff - 1'b1;
               if (ndig_ff == 4'd1) begin
                  last_in  = 1'b1;
                  done_in  = 1'b1;
                  state_in = E_IDLE;
               end
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= E_IDLE;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
      dig_ff   <= dig_in;
      ndig_ff  <= ndig_in;
      width_ff <= width_in;
      pad_ff   <= pad_in;
      neg_ff   <= neg_in;
      char_ff  <= char_in;
   end

   assign done      = done_in;
   assign active    = (state_ff != E_IDLE);
   assign strobe    = strobe_ff;
   assign character = char_ff;
   assign last      = last_ff;

endmodule

>>> rtl/core/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter
//
// Converts one 32-bit value per command into ASCII characters, most
// significant first. req_conversion selects signed decimal or unsigned
// uppercase hex; req_min_width sets the zero-padded digit count, which
// saturates at MAX_DIGITS and excludes the '-' sign.
// Command channel: a beat is taken at a clock edge with start high and busy
// low; busy stays high until the final character has been issued.
// Result channel: one character per cycle on rsp_character, marked by
// rsp_strobe, with rsp_last on the final character. The receiver cannot
// stall, so characters leave back to back once output begins.
// Sequence: decimal runs a bit-serial binary to bcd shift, hex skips it.
// Leading zero digits are then stripped one per cycle, keeping at least one
// digit, and characters follow at one per cycle.
// Reset (synchronous) returns every controller to idle and drops strobe.
module integer_to_ascii_formatter #(
   parameter int MAX_DIGITS = 49
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [i2a_pkg::VALUE_W-1:0]        req_value,
   input  logic                               req_conversion,
   input  logic [i2a_pkg::WIDTH_W-1:0]        req_min_width,
   output logic                               rsp_strobe,
   output logic [i2a_pkg::CHAR_W-1:0]         rsp_character,
   output logic                               rsp_last
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CONV = 3'b010,
      S_EMIT = 3'b100
   } top_state_type;

   top_state_type                   state_ff, state_in;
   logic                            neg_ff, neg_in;
   logic [i2a_pkg::WIDTH_W-1:0]     width_ff, width_in;
   logic                            accept;
   logic                            req_neg;
   logic [i2a_pkg::VALUE_W-1:0]     req_mag;
   logic [i2a_pkg::BCD_W-1:0]       bcd;
   logic                            conv_done;
   logic                            emit_done;
   logic                            emit_active;
   logic                            dabble_load;
   i2a_pkg::emit_cmd_type           cmd;

   assign accept  = start && !busy;
   assign req_neg = (req_conversion == i2a_pkg::CONV_DEC) && req_value[i2a_pkg::VALUE_W-1];
   assign req_mag = req_neg ? (~req_value + 1'b1) : req_value;
   assign dabble_load = accept && (req_conversion == i2a_pkg::CONV_DEC);

   // emit command: hex goes straight in, decimal after the bcd shift
   always_comb begin
      cmd = '0;
      if (accept && req_conversion == i2a_pkg::CONV_HEX) begin
         cmd.load   = 1'b1;
         cmd.neg    = 1'b0;
         cmd.digits = {{(i2a_pkg::BCD_W-i2a_pkg::VALUE_W){1'b0}}, req_value};
         cmd.width  = req_min_width;
      end else if (conv_done) begin
         cmd.load   = 1'b1;
         cmd.neg    = neg_ff;
         cmd.digits = bcd;
         cmd.width  = width_ff;
      end
   end

   // command controller
   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      width_in = width_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               neg_in   = req_neg;
               width_in = req_min_width;
               state_in = (req_conversion == i2a_pkg::CONV_HEX) ? S_EMIT : S_CONV;
            end
         end
         S_CONV: begin
            if (conv_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff   <= neg_in;
      width_ff <= width_in;
   end

   assign busy = (state_ff != S_IDLE);

   i2a_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .load      (dabble_load),
      .magnitude (req_mag),
      .bcd       (bcd),
      .done      (conv_done)
   );

   i2a_emit #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .done      (emit_done),
      .active    (emit_active),
      .strobe    (rsp_strobe),
      .character (rsp_character),
      .last      (rsp_last)
   );

   // a character that is not the final one means the command is still open
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
      else $error("non-final character issued while idle");

   // the final character is not directly followed by another character
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("character issued after the final one");

   // the sequencer stays idle while the bcd shift runs
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CONV |-> !emit_active && !rsp_strobe)
      else $error("sequencer active during conversion");

   // a fresh command never meets a character in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_strobe)
      else $error("character right after a new command");

endmodule
